[design/cartridge_bank_mapper_macros.svh]
// Assertion macros shared by the cartridge bank mapper modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_IMP(lbl, ck, rst_n, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("cartridge_bank_mapper: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NXT(lbl, ck, rst_n, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("cartridge_bank_mapper: next-cycle check failed");

`endif

[design/cbm_pkg.sv]
// Types, constants and helper functions of the cartridge bank mapper.
// Depends on nothing; used by every file of the block but the macros header.
package cbm_pkg;

	localparam int RAM_BANK_BYTES_DEF = 8192;
	localparam int MAX_RAM_BANKS_DEF  = 4;

	localparam int ROM_OFF_W   = 14;
	localparam int ROM_BANK_W  = 7;
	localparam int ROM_ADDR_W  = ROM_OFF_W + ROM_BANK_W;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;

	localparam int OQ_DEPTH = 3;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam logic [CFG_INDEX_W-1:0] REG_ROM_BANK_COUNT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_RAM_BANK_COUNT = 1'b1;

	localparam logic [1:0] SEL_RAM_ENABLE = 2'b00;
	localparam logic [1:0] SEL_ROM_LOW    = 2'b01;
	localparam logic [1:0] SEL_UPPER      = 2'b10;
	localparam logic [1:0] SEL_MODE       = 2'b11;

	localparam logic [3:0] RAM_EN_KEY  = 4'hA;
	localparam logic [7:0] ERR_BYTE    = 8'hFF;
	localparam logic [2:0] RAM_WINDOW  = 3'b101;
	localparam logic [7:0] ROM_CNT_RST = 8'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RAM_OFF  = 2'd1,
		ST_BAD_ADDR = 2'd2,
		ST_NO_RAM   = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]            read_data;
		logic                  rom_fetch;
		logic [ROM_ADDR_W-1:0] rom_address;
		status_t               status;
	} res_t;

	typedef struct packed {
		logic       we;
		logic       re;
		logic [7:0] wdata;
	} mem_req_t;

	// Reduces a RAM bank number below the number of banks fitted.
	function automatic logic [1:0] bank_mod(input logic [1:0] v, input logic [2:0] m);
		logic [1:0] r;
		r = v;
		for (int i = 0; i < 3; i++) begin
			if ({1'b0, r} >= m) begin
				r = r - m[1:0];
			end
		end
		return r;
	endfunction

endpackage

[design/cbm_ifs.sv]
// Handshake interfaces of the cartridge bank mapper: bus access, result and configuration.
// Depends on cbm_pkg for the field widths.
interface cbm_bus_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] address;
	logic [7:0]  write_value;

	modport source (output valid, command, address, write_value, input ready);
	modport sink (input valid, command, address, write_value, output ready);
endinterface

interface cbm_res_if;
	logic                           valid;
	logic                           ready;
	logic [7:0]                     read_data;
	logic                           rom_fetch;
	logic [cbm_pkg::ROM_ADDR_W-1:0] rom_address;
	logic [1:0]                     status;

	modport source (output valid, read_data, rom_fetch, rom_address, status, input ready);
	modport sink (input valid, read_data, rom_fetch, rom_address, status, output ready);
endinterface

interface cbm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [cbm_pkg::CFG_INDEX_W-1:0] index;
	logic [cbm_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/cbm_ctrl.sv]
// Bank registers, configuration registers and access decode of the bank mapper.
// Depends on cbm_pkg and the assertion macros header.
`include "cartridge_bank_mapper_macros.svh"

module cbm_ctrl #(
	parameter int RAM_BANK_BYTES = cbm_pkg::RAM_BANK_BYTES_DEF,
	parameter int MAX_RAM_BANKS  = cbm_pkg::MAX_RAM_BANKS_DEF,
	parameter int AW             = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_fire,
	input  logic [cbm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_fire,
	input  logic                            command,
	input  logic [15:0]                     address,
	input  logic [7:0]                      write_value,
	output cbm_pkg::mem_req_t               mem_req,
	output logic [AW-1:0]                   mem_index,
	output cbm_pkg::res_t                   res_s1,
	output logic                            use_mem_s1,
	output logic                            v_s1
);

	localparam logic [13:0] RB1 = 14'(RAM_BANK_BYTES);
	localparam logic [13:0] RB2 = 14'(2 * RAM_BANK_BYTES);

	logic [7:0] rom_bank_count_q;
	logic [2:0] ram_bank_count_q;
	logic [3:0] ram_enable_q;
	logic [4:0] rom_low_q;
	logic [1:0] upper_q;
	logic       mode_q;

	logic                               is_rom;
	logic                               is_ram;
	logic [cbm_pkg::ROM_BANK_W-1:0]     mask;
	logic [cbm_pkg::ROM_BANK_W-1:0]     high;
	logic [4:0]                         low_m;
	logic [4:0]                         low_nz;
	logic [cbm_pkg::ROM_BANK_W-1:0]     bank;
	logic [1:0]                         ram_bank;
	logic [13:0]                        off0;
	logic [13:0]                        off1;
	logic [13:0]                        off2;
	cbm_pkg::res_t                      res_d;
	logic                               use_mem_d;

	assign is_rom = !address[15];
	assign is_ram = (address[15:13] == cbm_pkg::RAM_WINDOW);
	assign mask   = cbm_pkg::ROM_BANK_W'(rom_bank_count_q - 8'd1);
	assign high   = {upper_q, 5'b0} & mask;
	assign low_m  = rom_low_q & mask[4:0];
	assign low_nz = (low_m == 5'd0) ? 5'd1 : low_m;
	assign bank   = address[14] ? ({2'b0, low_nz} | high)
	                            : (mode_q ? high : '0);

	assign ram_bank = mode_q ? cbm_pkg::bank_mod(upper_q & 2'(ram_bank_count_q - 3'd1),
	                                             3'(MAX_RAM_BANKS))
	                         : 2'd0;
	assign off0 = {1'b0, address[12:0]};
	assign off1 = (off0 >= RB2) ? off0 - RB2 : off0;
	assign off2 = (off1 >= RB1) ? off1 - RB1 : off1;
	assign mem_index = AW'(int'(ram_bank) * RAM_BANK_BYTES + int'(off2));

	always_comb begin
		res_d         = '{read_data: '0, rom_fetch: 1'b0, rom_address: '0,
		                  status: cbm_pkg::ST_OK};
		mem_req       = '{we: 1'b0, re: 1'b0, wdata: write_value};
		use_mem_d     = 1'b0;
		if (is_rom) begin
			if (!command) begin
				res_d.rom_fetch   = 1'b1;
				res_d.rom_address = {bank, address[cbm_pkg::ROM_OFF_W-1:0]};
			end
		end else if (is_ram) begin
			if (ram_enable_q != cbm_pkg::RAM_EN_KEY) begin
				res_d.status    = cbm_pkg::ST_RAM_OFF;
				res_d.read_data = cbm_pkg::ERR_BYTE;
			end else if (ram_bank_count_q == 3'd0) begin
				res_d.status    = cbm_pkg::ST_NO_RAM;
				res_d.read_data = cbm_pkg::ERR_BYTE;
			end else if (command) begin
				mem_req.we = 1'b1;
			end else begin
				mem_req.re = 1'b1;
				use_mem_d  = 1'b1;
			end
		end else begin
			res_d.status    = cbm_pkg::ST_BAD_ADDR;
			res_d.read_data = cbm_pkg::ERR_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_count_q <= cbm_pkg::ROM_CNT_RST;
			ram_bank_count_q <= '0;
			ram_enable_q     <= '0;
			rom_low_q        <= '0;
			upper_q          <= '0;
			mode_q           <= 1'b0;
			v_s1             <= 1'b0;
		end else begin
			v_s1 <= in_fire;
			if (cfg_fire) begin
				case (cfg_index)
					cbm_pkg::REG_ROM_BANK_COUNT: rom_bank_count_q <= cfg_data;
					cbm_pkg::REG_RAM_BANK_COUNT: ram_bank_count_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (in_fire && is_rom && command) begin
				case (address[14:13])
					cbm_pkg::SEL_RAM_ENABLE: ram_enable_q <= write_value[3:0];
					cbm_pkg::SEL_ROM_LOW:    rom_low_q    <= write_value[4:0];
					cbm_pkg::SEL_UPPER:      upper_q      <= write_value[1:0];
					cbm_pkg::SEL_MODE:       mode_q       <= write_value[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_s1     <= res_d;
			use_mem_s1 <= use_mem_d;
		end
	end

	`CBM_ASSERT_IMP(a_fetch_is_ok, clk, arst_n, v_s1 && res_s1.rom_fetch, res_s1.status == cbm_pkg::ST_OK)
	`CBM_ASSERT_IMP(a_mem_read_clean, clk, arst_n, v_s1 && use_mem_s1, !res_s1.rom_fetch && res_s1.status == cbm_pkg::ST_OK)
	`CBM_ASSERT_IMP(a_one_mem_op, clk, arst_n, 1'b1, !(mem_req.we && mem_req.re))

endmodule

[design/cbm_ram.sv]
// Cartridge RAM of the bank mapper, with the clearing sweep that runs after reset.
// Depends on cbm_pkg and the assertion macros header.
`include "cartridge_bank_mapper_macros.svh"

module cbm_ram #(
	parameter int DEPTH = cbm_pkg::RAM_BANK_BYTES_DEF * cbm_pkg::MAX_RAM_BANKS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  cbm_pkg::mem_req_t req,
	input  logic [AW-1:0]     index,
	output logic [7:0]        rdata_s1,
	output logic              clearing
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [7:0]    mem [DEPTH];
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;

	assign clearing = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == LAST) begin
				clr_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (fire && req.we) begin
			mem[index] <= req.wdata;
		end
		if (fire && req.re) begin
			rdata_s1 <= mem[index];
		end
	end

	`CBM_ASSERT_IMP(a_no_access_in_sweep, clk, arst_n, fire, !clr_q)
	`CBM_ASSERT_NXT(a_sweep_once, clk, arst_n, !clr_q, !clr_q)
	`CBM_ASSERT_IMP(a_index_in_range, clk, arst_n, fire && (req.we || req.re), index <= LAST)

endmodule

[design/cbm_outq.sv]
// Three-entry result queue that decouples the bus side from the result consumer.
// Depends on cbm_pkg and the assertion macros header.
`include "cartridge_bank_mapper_macros.svh"

module cbm_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  cbm_pkg::res_t                push_data,
	input  logic                         pop,
	output logic                         head_valid,
	output cbm_pkg::res_t                head,
	output logic [cbm_pkg::OQ_CNT_W-1:0] count
);

	localparam logic [cbm_pkg::OQ_PTR_W-1:0] LAST_PTR = cbm_pkg::OQ_PTR_W'(cbm_pkg::OQ_DEPTH - 1);
	localparam logic [cbm_pkg::OQ_CNT_W-1:0] FULL     = cbm_pkg::OQ_CNT_W'(cbm_pkg::OQ_DEPTH);

	cbm_pkg::res_t                ent_q [cbm_pkg::OQ_DEPTH];
	logic [cbm_pkg::OQ_PTR_W-1:0] wr_ptr_q;
	logic [cbm_pkg::OQ_PTR_W-1:0] rd_ptr_q;
	logic [cbm_pkg::OQ_CNT_W-1:0] count_q;

	assign count      = count_q;
	assign head_valid = (count_q != '0);
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	`CBM_ASSERT_IMP(a_no_overflow, clk, arst_n, push, count_q != FULL || pop)
	`CBM_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, count_q != '0)
	`CBM_ASSERT_NXT(a_ptrs_track_count, clk, arst_n, count_q == '0 && !push, wr_ptr_q == rd_ptr_q)

endmodule

[design/cartridge_bank_mapper.sv]
// Top level of the cartridge bank mapper: bank registers, cartridge RAM and result queue.
// Depends on cbm_pkg, cbm_ifs, cbm_ctrl, cbm_ram and cbm_outq.
//
// The mapper takes one bus transaction per cycle while ready and returns one result for each,
// in order: the access is decoded against the bank registers in the accepting cycle, the
// cartridge RAM is read or written at the edge that ends it, with the read data registered
// alongside the decoded access, and the result then waits in a three-entry queue. Bus ready
// depends only on the RAM sweep and queue occupancy, so a stalled consumer holds off new
// transactions without a combinational path from result ready to bus ready. After reset the
// RAM is swept to zero one byte per cycle, all MAX_RAM_BANKS * RAM_BANK_BYTES bytes (32768
// by default), and no bus transaction is accepted until the sweep ends; configuration
// writes are accepted throughout and take effect for the next bus transaction.
module cartridge_bank_mapper #(
	parameter int RAM_BANK_BYTES = cbm_pkg::RAM_BANK_BYTES_DEF,
	parameter int MAX_RAM_BANKS  = cbm_pkg::MAX_RAM_BANKS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cbm_bus_if.sink   bus,
	cbm_res_if.source result,
	cbm_cfg_if.sink   cfg
);

	localparam int DEPTH = RAM_BANK_BYTES * MAX_RAM_BANKS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [cbm_pkg::OQ_CNT_W:0] ROOM_LIMIT = (cbm_pkg::OQ_CNT_W + 1)'(cbm_pkg::OQ_DEPTH);

	logic                         in_fire;
	logic                         cfg_fire;
	logic                         clearing;
	cbm_pkg::mem_req_t            mem_req;
	logic [AW-1:0]                mem_index;
	cbm_pkg::res_t                res_s1;
	cbm_pkg::res_t                push_data;
	logic                         use_mem_s1;
	logic                         v_s1;
	logic [7:0]                   rdata_s1;
	cbm_pkg::res_t                head;
	logic                         head_valid;
	logic [cbm_pkg::OQ_CNT_W-1:0] count;
	logic [cbm_pkg::OQ_CNT_W:0]   occupancy;

	assign occupancy = {1'b0, count} + {{cbm_pkg::OQ_CNT_W{1'b0}}, v_s1};
	assign bus.ready = !clearing && (occupancy < ROOM_LIMIT);
	assign in_fire   = bus.valid && bus.ready;
	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	always_comb begin
		push_data = res_s1;
		if (use_mem_s1) begin
			push_data.read_data = rdata_s1;
		end
	end

	cbm_ctrl #(
		.RAM_BANK_BYTES(RAM_BANK_BYTES),
		.MAX_RAM_BANKS (MAX_RAM_BANKS),
		.AW            (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_fire   (cfg_fire),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.in_fire    (in_fire),
		.command    (bus.command),
		.address    (bus.address),
		.write_value(bus.write_value),
		.mem_req    (mem_req),
		.mem_index  (mem_index),
		.res_s1     (res_s1),
		.use_mem_s1 (use_mem_s1),
		.v_s1       (v_s1)
	);

	cbm_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (in_fire),
		.req     (mem_req),
		.index   (mem_index),
		.rdata_s1(rdata_s1),
		.clearing(clearing)
	);

	cbm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1),
		.push_data (push_data),
		.pop       (result.valid && result.ready),
		.head_valid(head_valid),
		.head      (head),
		.count     (count)
	);

	assign result.valid       = head_valid;
	assign result.read_data   = head.read_data;
	assign result.rom_fetch   = head.rom_fetch;
	assign result.rom_address = head.rom_address;
	assign result.status      = head.status;

endmodule
